// ===== sv/pow_difficulty_retarget_top_macros.svh =====
// Assertion macros shared by the retarget RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef POW_DIFFICULTY_RETARGET_TOP_MACROS_SVH
`define POW_DIFFICULTY_RETARGET_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define PDR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger implies a consequence in the next cycle.
`define PDR_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define PDR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define PDR_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif
`endif

// ===== sv/pdr_pkg.sv =====
// Shared constants and types for the difficulty retarget pipeline.
// No dependencies; used by every RTL module of the block.
package pdr_pkg;

    localparam int TGT_W       = 64;
    localparam int HEIGHT_W    = 31;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STEPS   = 64;
    localparam int MOD_STEPS   = 31;
    localparam int WINDOW_BLOCKS_DEF = 100;

    localparam logic [TGT_W-1:0] INIT_TARGET_RST = 64'd17592186044415;
    localparam logic [CFG_W-1:0] INTERVAL_RST    = 16'd100;
    localparam logic [CFG_W-1:0] BLOCK_SEC_RST   = 16'd6;
    localparam logic [TGT_W-1:0] TGT_MAX         = {TGT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TARGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETARGET_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SECONDS     = 2'd2;

    // Per-item payload carried down the pipeline
    typedef struct packed {
        logic [TGT_W-1:0]    nq;      // dividend low bits out, quotient bits in
        logic [HEIGHT_W-1:0] mod_hq;  // height bits shifting out
        logic [CFG_W-1:0]    mod_r;   // height modulo interval, partial
        logic [TGT_W-1:0]    tgt;     // selected old target
        logic [TGT_W-1:0]    lo_b;    // lower clamp bound
        logic [TGT_W-1:0]    hi_b;    // upper clamp bound
        logic                do_rt;   // retarget allowed, pending modulo check
        logic                sat;     // quotient overflows 64 bits
    } t_side;

endpackage

// ===== sv/pdr_mul.sv =====
// Two-stage 64x64 multiplier for target times elapsed time.
// Depends on pdr_pkg; feeds the first divider step with remainder and overflow flag.
module pdr_mul #(
    parameter int EXP_W = 23
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  pdr_pkg::t_side         i_side,
    input  logic [63:0]            i_elapsed,
    input  logic [EXP_W-1:0]       i_den,
    output logic                   o_valid,
    output pdr_pkg::t_side         o_side,
    output logic [EXP_W-1:0]       o_rem
);
    import pdr_pkg::*;

    logic        r_a_valid;
    t_side       r_a_side;
    logic [63:0] r_ll, r_lh, r_hl, r_hh;
    logic        r_b_valid;
    t_side       r_b_side;
    logic [EXP_W-1:0] r_b_rem;
    logic [127:0] w_prod;
    t_side        n_b_side;

    // Stage A: partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_side <= i_side;
            r_ll <= 64'(i_side.tgt[31:0])  * 64'(i_elapsed[31:0]);
            r_lh <= 64'(i_side.tgt[31:0])  * 64'(i_elapsed[63:32]);
            r_hl <= 64'(i_side.tgt[63:32]) * 64'(i_elapsed[31:0]);
            r_hh <= 64'(i_side.tgt[63:32]) * 64'(i_elapsed[63:32]);
        end
    end

    // Stage B: sum, overflow check against the divisor
    always_comb begin
        w_prod = {r_hh, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0};
        n_b_side     = r_a_side;
        n_b_side.nq  = w_prod[63:0];
        n_b_side.sat = (w_prod[127:64] >= 64'(i_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_side <= n_b_side;
            r_b_rem  <= w_prod[64 +: EXP_W];
        end
    end

    assign o_valid = r_b_valid;
    assign o_side  = r_b_side;
    assign o_rem   = r_b_rem;

endmodule

// ===== sv/pdr_div_step.sv =====
// One registered restoring-division step, with an optional height modulo step.
// Depends on pdr_pkg; chained in the top level.
module pdr_div_step #(
    parameter int EXP_W  = 23,
    parameter bit DO_MOD = 1'b1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  pdr_pkg::t_side         i_side,
    input  logic [EXP_W-1:0]       i_rem,
    input  logic [EXP_W-1:0]       i_den,
    input  logic [pdr_pkg::CFG_W-1:0] i_interval,
    output logic                   o_valid,
    output pdr_pkg::t_side         o_side,
    output logic [EXP_W-1:0]       o_rem
);
    import pdr_pkg::*;

    logic [EXP_W:0]   w_sh;
    logic             w_ge;
    logic [EXP_W:0]   w_diff;
    logic [CFG_W:0]   w_msh;
    logic [CFG_W:0]   w_mdiff;
    logic             w_mge;
    t_side            n_side;
    logic [EXP_W-1:0] n_rem;
    logic             r_valid;
    t_side            r_side;
    logic [EXP_W-1:0] r_rem;

    // Shift in next dividend bit, subtract when it fits
    always_comb begin
        w_sh   = {i_rem, i_side.nq[TGT_W-1]};
        w_ge   = (w_sh >= {1'b0, i_den});
        w_diff = w_sh - {1'b0, i_den};
        n_rem  = w_ge ? w_diff[EXP_W-1:0] : w_sh[EXP_W-1:0];
        n_side = i_side;
        n_side.nq = {i_side.nq[TGT_W-2:0], w_ge};
        w_msh   = {i_side.mod_r, i_side.mod_hq[HEIGHT_W-1]};
        w_mge   = (w_msh >= {1'b0, i_interval});
        w_mdiff = w_msh - {1'b0, i_interval};
        if (DO_MOD) begin
            n_side.mod_hq = {i_side.mod_hq[HEIGHT_W-2:0], 1'b0};
            n_side.mod_r  = w_mge ? w_mdiff[CFG_W-1:0] : w_msh[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= n_side;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;

endmodule

// ===== sv/pow_difficulty_retarget_top.sv =====
// Top level of the proof-of-work difficulty retarget pipeline.
// Depends on pdr_pkg, pdr_mul, pdr_div_step and the assertion macro header.
//
// One request enters per cycle while the pipeline is not held, and passes through one
// input stage, two multiplier stages, 64 restoring-division stages (one
// quotient bit each; the first 31 also compute height modulo the interval)
// and one clamp stage that is the output register. The whole pipeline holds
// while a result waits under i_stall. Configuration writes are always ready
// and must only arrive while no request is in flight.
`include "pow_difficulty_retarget_top_macros.svh"
module pow_difficulty_retarget_top #(
    parameter int WINDOW_BLOCKS = pdr_pkg::WINDOW_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pdr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pdr_pkg::TGT_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [pdr_pkg::HEIGHT_W-1:0]  i_chain_height,
    input  logic [pdr_pkg::TGT_W-1:0]     i_prev_target,
    input  logic [pdr_pkg::TGT_W-1:0]     i_window_start_time,
    input  logic [pdr_pkg::TGT_W-1:0]     i_window_end_time,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [pdr_pkg::TGT_W-1:0]     o_next_target,
    output logic                          o_retargeted
);
    import pdr_pkg::*;

    localparam int EXP_W = CFG_W + $clog2(WINDOW_BLOCKS + 1);

    logic [TGT_W-1:0] r_initial_target;
    logic [CFG_W-1:0] r_retarget_interval;
    logic [CFG_W-1:0] r_block_seconds;
    logic [CFG_W-1:0] w_bs_eff;
    logic [EXP_W-1:0] w_expect;
    logic             w_adv;

    logic             r_s1_valid;
    t_side            r_s1_side;
    logic [TGT_W-1:0] r_s1_elapsed;
    t_side            n_s1_side;
    logic [TGT_W-1:0] n_s1_elapsed;
    logic [TGT_W-1:0] w_tgt_sel;
    logic [TGT_W-1:0] w_lo;

    logic             w_vld  [0:DIV_STEPS];
    t_side            w_side [0:DIV_STEPS];
    logic [EXP_W-1:0] w_rem  [0:DIV_STEPS];

    t_side            w_fin;
    logic             w_rt;
    logic [TGT_W-1:0] w_nt;
    logic [TGT_W-1:0] w_cl;
    logic [TGT_W-1:0] n_target;
    logic             r_out_valid;
    logic [TGT_W-1:0] r_next_target;
    logic             r_retargeted;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_target    <= INIT_TARGET_RST;
            r_retarget_interval <= INTERVAL_RST;
            r_block_seconds     <= BLOCK_SEC_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_INITIAL_TARGET:    r_initial_target    <= i_cfg_data;
                CFG_RETARGET_INTERVAL: r_retarget_interval <= i_cfg_data[CFG_W-1:0];
                CFG_BLOCK_SECONDS:     r_block_seconds     <= i_cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Expected window time; the user must keep it static while requests are in flight, the block does not enforce it
    assign w_bs_eff = (r_block_seconds == '0) ? CFG_W'(1) : r_block_seconds;
    assign w_expect = EXP_W'(WINDOW_BLOCKS) * EXP_W'(w_bs_eff);

    // Advance the whole pipeline unless the output holds a stalled result
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // Stage 1: select target, bounds, elapsed time
    always_comb begin
        w_tgt_sel = (i_chain_height == '0 || i_prev_target == '0) ?
                    r_initial_target : i_prev_target;
        w_lo      = w_tgt_sel >> 2;
        n_s1_side = '0;
        n_s1_side.tgt    = w_tgt_sel;
        n_s1_side.lo_b   = (w_lo == '0) ? TGT_W'(1) : w_lo;
        n_s1_side.hi_b   = (w_tgt_sel[TGT_W-1:TGT_W-2] != 2'b00) ? TGT_MAX :
                           {w_tgt_sel[TGT_W-3:0], 2'b00};
        n_s1_side.mod_hq = i_chain_height;
        // Window spans a block only from height three on
        n_s1_side.do_rt  = (i_chain_height >= HEIGHT_W'(3)) && (w_tgt_sel != '0) &&
                           (r_retarget_interval != '0);
        n_s1_elapsed = i_window_end_time - i_window_start_time;
        if (n_s1_elapsed == '0) begin
            n_s1_elapsed = TGT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
        end
        if (w_adv) begin
            r_s1_side    <= n_s1_side;
            r_s1_elapsed <= n_s1_elapsed;
        end
    end

    // Multiply
    pdr_mul #(.EXP_W(EXP_W)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (r_s1_valid),
        .i_side    (r_s1_side),
        .i_elapsed (r_s1_elapsed),
        .i_den     (w_expect),
        .o_valid   (w_vld[0]),
        .o_side    (w_side[0]),
        .o_rem     (w_rem[0])
    );

    // Divide, one quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        pdr_div_step #(
            .EXP_W  (EXP_W),
            .DO_MOD (k < MOD_STEPS)
        ) u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_adv),
            .i_valid    (w_vld[k]),
            .i_side     (w_side[k]),
            .i_rem      (w_rem[k]),
            .i_den      (w_expect),
            .i_interval (r_retarget_interval),
            .o_valid    (w_vld[k+1]),
            .o_side     (w_side[k+1]),
            .o_rem      (w_rem[k+1])
        );
    end

    // Final stage: saturate, clamp, never zero
    always_comb begin
        w_fin = w_side[DIV_STEPS];
        w_rt  = w_fin.do_rt && (w_fin.mod_r == '0);
        w_nt  = w_fin.sat ? TGT_MAX : w_fin.nq;
        if (w_nt < w_fin.lo_b) begin
            w_cl = w_fin.lo_b;
        end else if (w_nt > w_fin.hi_b) begin
            w_cl = w_fin.hi_b;
        end else begin
            w_cl = w_nt;
        end
        n_target = w_rt ? w_cl : w_fin.tgt;
        if (n_target == '0) begin
            n_target = TGT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vld[DIV_STEPS];
        end
        if (w_adv) begin
            r_next_target <= n_target;
            r_retargeted  <= w_rt;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_target = r_next_target;
    assign o_retargeted  = r_retargeted;

    `PDR_ASSERT_ALWAYS(a_nonzero_result, i_clk, i_rst_n, !o_valid || o_next_target != '0, "zero target delivered")
    `PDR_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, o_stall && r_s1_valid, r_s1_valid && $stable(r_s1_elapsed), "stage 1 moved under stall")
    `PDR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_stall, r_out_valid && $stable(r_retargeted), "result dropped under stall")

endmodule

// ===== tb/tb_pow_difficulty_retarget_top.sv =====
// Self-checking testbench for the proof-of-work difficulty retarget pipeline.
// Depends on pdr_pkg and pow_difficulty_retarget_top; predicts every target in SV.
`timescale 1ns / 100ps
module tb_pow_difficulty_retarget_top;
    import pdr_pkg::*;

    localparam int WINDOW    = WINDOW_BLOCKS_DEF;
    localparam int LATENCY   = 68;
    localparam int MAX_CYCLE = 1000000;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic [TGT_W-1:0]    prev;
        logic [TGT_W-1:0]    t_start;
        logic [TGT_W-1:0]    t_end;
    } header_t;

    typedef struct {
        logic [TGT_W-1:0] target;
        logic             retargeted;
    } target_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TGT_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [HEIGHT_W-1:0]  i_chain_height;
    logic [TGT_W-1:0]     i_prev_target;
    logic [TGT_W-1:0]     i_window_start_time;
    logic [TGT_W-1:0]     i_window_end_time;
    logic                 o_valid;
    logic                 i_stall;
    logic [TGT_W-1:0]     o_next_target;
    logic                 o_retargeted;

    // Model copy of the configuration registers
    logic [TGT_W-1:0] init_target;
    logic [CFG_W-1:0] interval;
    logic [CFG_W-1:0] block_sec;

    header_t pending_headers[$];
    target_t expected_targets[$];
    header_t cur_header;
    int      queued_cnt;
    int      accepted_cnt;
    int      checked_cnt;
    int      retarget_cnt;
    int      mismatch_cnt;
    int      send_gap;
    int      recv_gap;
    bit      no_idle;
    bit      hold_req;
    int      hold_cycles;
    int      cycle_cnt;

    pow_difficulty_retarget_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_chain_height      (i_chain_height),
        .i_prev_target       (i_prev_target),
        .i_window_start_time (i_window_start_time),
        .i_window_end_time   (i_window_end_time),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_next_target       (o_next_target),
        .o_retargeted        (o_retargeted)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Compute the next target for one header under the current registers
    function automatic target_t next_target_of(header_t h);
        target_t          r;
        logic [TGT_W-1:0] tgt, elapsed, lo_b, hi_b, expected_time;
        logic [127:0]     quot;
        logic [31:0]      last, first;
        r.retargeted = 1'b0;
        if (h.height == 0) begin
            tgt = init_target;
        end else begin
            tgt = (h.prev == 0) ? init_target : h.prev;
            if (interval != 0 && h.height >= interval && h.height % interval == 0) begin
                last  = h.height - 1;
                first = (last > WINDOW) ? last - WINDOW : 1;
                if (first < last && tgt != 0) begin
                    elapsed = h.t_end - h.t_start;
                    if (elapsed == 0)
                        elapsed = 1;
                    expected_time = WINDOW * ((block_sec == 0) ? 64'd1 : 64'(block_sec));
                    lo_b = tgt >> 2;
                    if (lo_b == 0)
                        lo_b = 1;
                    hi_b = (tgt > (TGT_MAX >> 2)) ? TGT_MAX : tgt << 2;
                    quot = (128'(tgt) * 128'(elapsed)) / 128'(expected_time);
                    tgt  = (quot > 128'(TGT_MAX)) ? TGT_MAX : quot[63:0];
                    if (tgt < lo_b)
                        tgt = lo_b;
                    else if (tgt > hi_b)
                        tgt = hi_b;
                    r.retargeted = 1'b1;
                end
            end
        end
        r.target = (tgt == 0) ? 64'd1 : tgt;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_header(logic [HEIGHT_W-1:0] height, logic [TGT_W-1:0] prev,
                              logic [TGT_W-1:0] t_start, logic [TGT_W-1:0] t_end);
        header_t h;
        h.height  = height;
        h.prev    = prev;
        h.t_start = t_start;
        h.t_end   = t_end;
        pending_headers.push_back(h);
        queued_cnt++;
    endtask

    // Mostly retarget-point headers with plausible timing, the rest noise
    task automatic add_random_headers(int count);
        logic [HEIGHT_W-1:0] height;
        logic [TGT_W-1:0]    prev, t0, span;
        int                  sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (interval != 0 && sel < 65) begin
                if ($urandom_range(0, 3) == 0)
                    height = interval * $urandom_range(1, 3);
                else
                    height = interval * $urandom_range(1, HEIGHT_MAX / interval);
            end else if (sel < 70) begin
                height = $urandom_range(0, 3);
            end else begin
                height = rand64();
            end
            case ($urandom_range(0, 5))
                0:       prev = 0;
                1:       prev = $urandom_range(1, 7);
                2:       prev = TGT_MAX - $urandom_range(0, 3);
                3:       prev = rand64() >> $urandom_range(0, 63);
                default: prev = rand64();
            endcase
            t0 = rand64();
            case ($urandom_range(0, 4))
                0:       span = rand64();
                1:       span = $urandom_range(0, 3);
                default: span = WINDOW * ((block_sec == 0) ? 1 : block_sec)
                               * $urandom_range(0, 600) / 100;
            endcase
            add_header(height, prev, t0, t0 + span);
        end
    endtask

    task automatic wait_drain();
        while (accepted_cnt != queued_cnt || expected_targets.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [TGT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_INITIAL_TARGET:    init_target = data;
            CFG_RETARGET_INTERVAL: interval    = data[CFG_W-1:0];
            CFG_BLOCK_SECONDS:     block_sec   = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [TGT_W-1:0] tgt, logic [TGT_W-1:0] iv,
                            logic [TGT_W-1:0] bs);
        write_reg(CFG_INITIAL_TARGET, tgt);
        write_reg(CFG_RETARGET_INTERVAL, iv);
        write_reg(CFG_BLOCK_SECONDS, bs);
    endtask

    // Stimulus and phase sequencing
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_INITIAL_TARGET;
        i_cfg_data     = '0;
        init_target    = INIT_TARGET_RST;
        interval       = INTERVAL_RST;
        block_sec      = BLOCK_SEC_RST;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        queued_cnt     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers under reset registers
        add_header(0, 64'd5, 0, 0);                       // genesis
        add_header(1, 0, 0, 10);                          // zero prev target
        add_header(100, 64'd1000000, 64'd0, 64'd600);     // on schedule
        add_header(100, 64'd1000000, 64'd77, 64'd77);     // zero elapsed
        add_header(100, 64'd1000000, 64'd50, 64'd10);     // wrapped elapsed
        add_header(100, TGT_MAX, 0, TGT_MAX);             // saturate
        add_header(200, 64'd1000000, 0, 64'd1);           // lower clamp
        add_header(200, 64'd1000000, 0, 64'd100000);      // upper clamp
        add_header(300, 64'd1, 0, 64'd1);                 // tiny target, floor of one
        add_header(300, 64'd3, 0, 64'd100000);
        add_header(HEIGHT_MAX, TGT_MAX, TGT_MAX, 0);      // not a multiple
        add_header(99, 64'd1234, 0, 64'd9999);
        add_header(101, 0, 0, 64'd1);
        add_header(2147483600, TGT_MAX, 0, 64'd1);        // multiple near height limit
        wait_drain();

        // Interval one: short-window heights and extremes
        set_regs(TGT_MAX, 64'd1, 64'd1);
        add_header(1, 64'd500, 0, 64'd1000);
        add_header(2, 64'd500, 0, 64'd1000);
        add_header(3, 64'd500, 0, 64'd1000);
        add_header(0, 0, TGT_MAX, TGT_MAX);
        add_header(102, 0, 0, TGT_MAX);
        add_header(HEIGHT_MAX, 64'd2, 64'd5, 64'd4);
        add_random_headers(300);
        hold_req = 1'b1;
        wait_drain();

        // Zero initial target, widest interval and block time
        set_regs(64'd0, 64'hFFFF, 64'hFFFF);
        add_header(0, 0, 0, 0);
        add_header(65535, 0, 0, 64'd10);
        add_random_headers(300);
        wait_drain();

        // Zero interval and zero block time
        set_regs(rand64(), 64'd0, 64'd0);
        add_header(100, 64'd800, 0, 64'd1);
        add_random_headers(300);
        wait_drain();

        // Upper bits of narrow registers are dropped; back-to-back traffic
        no_idle = 1'b1;
        set_regs(64'd1, 64'hABCD_0000_0000_0007, 64'hFFFF_0000_0000_000D);
        add_header(14, 64'd1000, 0, 64'd1);
        add_random_headers(200);
        wait_drain();
        no_idle = 1'b0;

        set_regs(rand64(), $urandom_range(1, 200), $urandom_range(1, 20));
        add_random_headers(426);
        wait_drain();

        $display("Covered %0d headers, %0d results checked, %0d of them retargeted,",
                 accepted_cnt, checked_cnt, retarget_cnt);
        $display("across six register settings including zero and full-scale values.");
        if (mismatch_cnt == 0 && expected_targets.size() == 0 && checked_cnt == queued_cnt)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Request driver: hold payload while stalled, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid             <= 1'b0;
            i_chain_height      <= '0;
            i_prev_target       <= '0;
            i_window_start_time <= '0;
            i_window_end_time   <= '0;
            send_gap            <= 0;
            accepted_cnt        <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_targets.push_back(next_target_of(cur_header));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_headers.size() > 0) begin
                    cur_header = pending_headers.pop_front();
                    i_chain_height      <= cur_header.height;
                    i_prev_target       <= cur_header.prev;
                    i_window_start_time <= cur_header.t_start;
                    i_window_end_time   <= cur_header.t_end;
                    i_valid             <= 1'b1;
                    send_gap            <= pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
        end else if (hold_req && hold_cycles == 0 && accepted_cnt > 60) begin
            hold_cycles <= 400;
            hold_req    <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Result monitor: compare each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        target_t exp_t;
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            recv_gap     <= 0;
            checked_cnt  <= 0;
            retarget_cnt <= 0;
            mismatch_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                checked_cnt <= checked_cnt + 1;
                if (expected_targets.size() == 0) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("unexpected result: target %h retargeted %b",
                                 o_next_target, o_retargeted);
                end else begin
                    exp_t = expected_targets.pop_front();
                    if (exp_t.retargeted)
                        retarget_cnt <= retarget_cnt + 1;
                    if (o_next_target !== exp_t.target
                            || o_retargeted !== exp_t.retargeted) begin
                        mismatch_cnt <= mismatch_cnt + 1;
                        if (mismatch_cnt < 10)
                            $display("result %0d: expected %h/%b, got %h/%b", checked_cnt,
                                     exp_t.target, exp_t.retargeted,
                                     o_next_target, o_retargeted);
                    end
                end
            end
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall  <= 1'b1;
            end else begin
                recv_gap <= pick_gap();
                i_stall  <= 1'b0;
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_cnt <= 0;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt > MAX_CYCLE) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
